### src/range_assign_point_query_tree_unit_assert.svh
// Assertion macros for the range assign / point query tree unit
`ifndef RANGE_ASSIGN_POINT_QUERY_TREE_UNIT_ASSERT_SVH
`define RANGE_ASSIGN_POINT_QUERY_TREE_UNIT_ASSERT_SVH

// same-cycle implication
`define RAPQ_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RAPQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/rapq_pkg.sv
// Package: constants, types and state encoding of the range assign tree unit
`default_nettype none
package rapq_pkg;

    localparam int LEAVES     = 1024;
    localparam int VALUE_BITS = 32;
    localparam int STAMP_BITS = 32;

    localparam int TREE_N     = 1 << $clog2(LEAVES);
    localparam int NODE_COUNT = 2 * TREE_N - 1;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int HEAP_W     = $clog2(TREE_N) + 2;
    localparam int ENTRY_W    = VALUE_BITS + STAMP_BITS;

    localparam int EDGE_W     = 11;
    localparam int POS_W      = 10;
    localparam int FIELD_W    = 32;

    localparam logic MODE_ASSIGN    = 1'b0;
    localparam logic MODE_READ      = 1'b1;
    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ASSIGN,
        ST_READ,
        ST_FINISH
    } rapq_state_t;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [NODE_W-1:0]  addr;
        logic [ENTRY_W-1:0] wdata;
    } rapq_ram_req_t;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] read_value;
        logic                  status;
    } rapq_result_t;

    typedef struct packed {
        logic clearing;
        logic writing;
    } rapq_stat_t;

endpackage
`default_nettype wire

### src/rapq_if.sv
// Command and result channel interfaces
`default_nettype none
interface rapq_cmd_if
    import rapq_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [EDGE_W-1:0]         left;
    logic [EDGE_W-1:0]         right;
    logic signed [FIELD_W-1:0] value;
    logic [POS_W-1:0]          position;

    modport source (output valid, mode, left, right, value, position, input ready);
    modport sink (input valid, mode, left, right, value, position, output ready);
endinterface

interface rapq_res_if
    import rapq_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] read_value;
    logic                      status;

    modport source (output valid, read_value, status, input ready);
    modport sink (input valid, read_value, status, output ready);
endinterface
`default_nettype wire

### src/rapq_ram.sv
// Single-port synchronous RAM with registered read data
`default_nettype none
module rapq_ram #(
    parameter int DEPTH  = 2047,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule
`default_nettype wire

### src/rapq_ctrl.sv
// Sequencer: clear pass, range cover walk and leaf-to-root read walk
`default_nettype none
module rapq_ctrl
    import rapq_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    rapq_cmd_if.sink           cmd,
    input  wire logic          out_free,
    input  wire logic [ENTRY_W-1:0] rdata,
    output rapq_ram_req_t      ram_req,
    output rapq_result_t       result,
    output rapq_stat_t         stat
);

    rapq_state_t state_reg, state_next;

    logic [NODE_W-1:0]     clr_reg, clr_next;
    logic [HEAP_W-1:0]     l_reg, l_next;
    logic [HEAP_W-1:0]     r_reg, r_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [STAMP_BITS-1:0] stamp_reg, stamp_next;
    logic [NODE_W-1:0]     k_reg, k_next;
    logic                  issue_reg, issue_next;
    logic                  issue_first_reg, issue_first_next;
    logic                  lat_reg, lat_next;
    logic                  lat_first_reg, lat_first_next;
    logic                  lat_last_reg, lat_last_next;
    logic [VALUE_BITS-1:0] best_reg, best_next;
    logic [STAMP_BITS-1:0] when_reg, when_next;
    logic [VALUE_BITS-1:0] res_val_reg, res_val_next;
    logic                  res_stat_reg, res_stat_next;

    logic [EDGE_W-1:0]     a_clamp, b_clamp;
    logic                  range_live;
    logic [STAMP_BITS-1:0] stamp_d;
    logic [VALUE_BITS-1:0] val_d;
    logic                  take_d;
    logic                  pos_ok;

    assign a_clamp    = (int'(cmd.left) > LEAVES) ? EDGE_W'(LEAVES) : cmd.left;
    assign b_clamp    = (int'(cmd.right) > LEAVES) ? EDGE_W'(LEAVES) : cmd.right;
    assign range_live = l_reg < r_reg;
    assign stamp_d    = rdata[STAMP_BITS-1:0];
    assign val_d      = rdata[ENTRY_W-1:STAMP_BITS];
    assign take_d     = lat_first_reg || (stamp_d > when_reg);
    assign pos_ok     = int'(cmd.position) < LEAVES;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == NODE_W'(NODE_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.mode == MODE_READ)
                    begin
                        state_next = pos_ok ? ST_READ : ST_FINISH;
                    end
                    else
                    begin
                        state_next = (stamp_reg == '0) ? ST_FINISH : ST_ASSIGN;
                    end
                end
            end
            ST_ASSIGN:
            begin
                if (!range_live)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ:
            begin
                if (lat_reg && lat_last_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ram_req.we        = 1'b0;
        ram_req.re        = 1'b0;
        ram_req.addr      = '0;
        ram_req.wdata     = {val_reg, stamp_reg};
        cmd.ready         = 1'b0;
        result.done       = 1'b0;
        result.read_value = res_val_reg;
        result.status     = res_stat_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.addr  = clr_reg;
                ram_req.wdata = '0;
            end
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
            end
            ST_ASSIGN:
            begin
                if (range_live && l_reg[0])
                begin
                    ram_req.we   = 1'b1;
                    ram_req.addr = NODE_W'(l_reg - HEAP_W'(1));
                end
                else if (range_live && r_reg[0])
                begin
                    ram_req.we   = 1'b1;
                    ram_req.addr = NODE_W'(r_reg - HEAP_W'(2));
                end
            end
            ST_READ:
            begin
                ram_req.re   = issue_reg;
                ram_req.addr = k_reg;
            end
            ST_FINISH:
            begin
                result.done = out_free;
            end
            default:
            begin
                ram_req.we = 1'b0;
            end
        endcase
    end

    assign stat.clearing     = (state_reg == ST_CLEAR);
    assign stat.writing      = ram_req.we;

    // datapath
    always_comb
    begin
        clr_next         = clr_reg;
        l_next           = l_reg;
        r_next           = r_reg;
        val_next         = val_reg;
        stamp_next       = stamp_reg;
        k_next           = k_reg;
        issue_next       = issue_reg;
        issue_first_next = issue_first_reg;
        lat_next         = 1'b0;
        lat_first_next   = 1'b0;
        lat_last_next    = 1'b0;
        best_next        = best_reg;
        when_next        = when_reg;
        res_val_next     = res_val_reg;
        res_stat_next    = res_stat_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + NODE_W'(1);
            end
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    res_val_next  = '0;
                    res_stat_next = STATUS_DONE;
                    if (cmd.mode == MODE_READ)
                    begin
                        k_next           = NODE_W'(cmd.position) + NODE_W'(TREE_N - 1);
                        issue_next       = pos_ok;
                        issue_first_next = 1'b1;
                    end
                    else if (stamp_reg == '0)
                    begin
                        res_stat_next = STATUS_REFUSED;
                    end
                    else
                    begin
                        l_next   = HEAP_W'(a_clamp) + HEAP_W'(TREE_N);
                        r_next   = HEAP_W'(b_clamp) + HEAP_W'(TREE_N);
                        val_next = VALUE_BITS'(cmd.value);
                    end
                end
            end
            ST_ASSIGN:
            begin
                if (range_live)
                begin
                    if (l_reg[0])
                    begin
                        l_next = l_reg + HEAP_W'(1);
                    end
                    else if (r_reg[0])
                    begin
                        r_next = r_reg - HEAP_W'(1);
                    end
                    else
                    begin
                        l_next = l_reg >> 1;
                        r_next = r_reg >> 1;
                    end
                end
                else
                begin
                    stamp_next = stamp_reg + STAMP_BITS'(1);
                end
            end
            ST_READ:
            begin
                if (issue_reg)
                begin
                    lat_next         = 1'b1;
                    lat_first_next   = issue_first_reg;
                    lat_last_next    = (k_reg == '0);
                    issue_first_next = 1'b0;
                    if (k_reg == '0)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        k_next = (k_reg - NODE_W'(1)) >> 1;
                    end
                end
                if (lat_reg && take_d)
                begin
                    best_next = val_d;
                    when_next = stamp_d;
                end
                if (lat_reg && lat_last_reg)
                begin
                    res_val_next = take_d ? val_d : best_reg;
                end
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            stamp_reg       <= STAMP_BITS'(1);
            issue_reg       <= 1'b0;
            issue_first_reg <= 1'b0;
            lat_reg         <= 1'b0;
            lat_first_reg   <= 1'b0;
            lat_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            stamp_reg       <= stamp_next;
            issue_reg       <= issue_next;
            issue_first_reg <= issue_first_next;
            lat_reg         <= lat_next;
            lat_first_reg   <= lat_first_next;
            lat_last_reg    <= lat_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg        <= l_next;
        r_reg        <= r_next;
        val_reg      <= val_next;
        k_reg        <= k_next;
        best_reg     <= best_next;
        when_reg     <= when_next;
        res_val_reg  <= res_val_next;
        res_stat_reg <= res_stat_next;
    end

endmodule
`default_nettype wire

### src/range_assign_point_query_tree_unit.sv
// Top level of the range assign / point query tree unit
// After reset the node memory is cleared, one node per cycle, all 2047 nodes
// (NODE_COUNT), during which no command is taken. A range assign then writes
// the covering node at the left edge, else the one at the right edge, else
// climbs one level, until the range is empty, and then advances the stamp.
// A refused assign writes no node.
// A point read walks the eleven nodes from leaf to root, one read a cycle.
// The node memory is single-port and holds value and stamp side by side. One
// command is in work at a time; the result sits in an output register so the
// next command is taken while it waits to be transferred.
`default_nettype none
`include "range_assign_point_query_tree_unit_assert.svh"
module range_assign_point_query_tree_unit
    import rapq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rapq_cmd_if.sink  cmd,
    rapq_res_if.source res
);

    rapq_ram_req_t         ram_req;
    rapq_result_t          result;
    rapq_stat_t            stat;
    logic [ENTRY_W-1:0]    rdata;
    logic                  out_free;

    logic                  res_valid_reg, res_valid_next;
    logic [VALUE_BITS-1:0] res_val_reg;
    logic                  res_stat_reg;

    assign out_free = !res_valid_reg || res.ready;

    rapq_ram #(
        .DEPTH  (NODE_COUNT),
        .WIDTH  (ENTRY_W),
        .ADDR_W (NODE_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .re    (ram_req.re),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (rdata)
    );

    rapq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .out_free (out_free),
        .rdata    (rdata),
        .ram_req  (ram_req),
        .result   (result),
        .stat     (stat)
    );

    assign res_valid_next = result.done || (res_valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.done)
        begin
            res_val_reg  <= result.read_value;
            res_stat_reg <= result.status;
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.read_value = FIELD_W'($signed(res_val_reg));
    assign res.status     = res_stat_reg;

    `RAPQ_ASSERT_IMPLY(a_clear_blocks_cmd, clk, rst_n, stat.clearing, !cmd.ready, "command taken during clear pass")
    `RAPQ_ASSERT_IMPLY(a_write_not_idle, clk, rst_n, stat.writing, !cmd.ready, "node write while idle")
    `RAPQ_ASSERT_IMPLY(a_done_slot_free, clk, rst_n, result.done && res_valid_reg, res.ready, "result overwrites pending transfer")
    `RAPQ_ASSERT_NEXT(a_done_shows, clk, rst_n, result.done, res.valid, "finished result not presented")
    `RAPQ_ASSERT_IMPLY(a_refused_zero, clk, rst_n, res.valid && res.status == STATUS_REFUSED, res.read_value == '0, "refused assign with non-zero value")

endmodule
`default_nettype wire

### test/range_assign_point_query_tree_unit_checker.sv
// Checker: predicts tree command answers and compares them with the result channel
module range_assign_point_query_tree_unit_checker
    import rapq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rapq_cmd_if  cmd,
    rapq_res_if  res,
    output int   fail_count,
    output int   pending
);

    typedef struct {
        logic signed [FIELD_W-1:0] read_value;
        logic                      status;
    } answer_t;

    logic [VALUE_BITS-1:0] node_val [NODE_COUNT];
    logic [STAMP_BITS-1:0] node_age [NODE_COUNT];
    logic [STAMP_BITS-1:0] stamp_now;
    answer_t               due_answers [$];
    int                    faults;

    // fewest covering nodes of [a,b) get (v, stamp_now)
    function automatic void paint(input int node, input int lo, input int hi,
                                  input int a, input int b,
                                  input logic [VALUE_BITS-1:0] v);
        int mid;
        if (b <= lo || hi <= a || node >= NODE_COUNT)
        begin
            return;
        end
        if (a <= lo && hi <= b)
        begin
            node_val[node] = v;
            node_age[node] = stamp_now;
            return;
        end
        mid = lo + (hi - lo) / 2;
        paint(node * 2 + 1, lo, mid, a, b, v);
        paint(node * 2 + 2, mid, hi, a, b, v);
    endfunction

    // leaf to root, strictly newer stamp wins
    function automatic logic [VALUE_BITS-1:0] leaf_read(input int pos);
        int                    k;
        logic [VALUE_BITS-1:0] best;
        logic [STAMP_BITS-1:0] newest;
        k      = pos + TREE_N - 1;
        best   = node_val[k];
        newest = node_age[k];
        while (k > 0)
        begin
            k = (k - 1) / 2;
            if (node_age[k] > newest)
            begin
                best   = node_val[k];
                newest = node_age[k];
            end
        end
        return best;
    endfunction

    function automatic answer_t tree_answer(input logic mode,
                                            input logic [EDGE_W-1:0] l,
                                            input logic [EDGE_W-1:0] r,
                                            input logic signed [FIELD_W-1:0] value,
                                            input logic [POS_W-1:0] pos);
        answer_t ans;
        int      a;
        int      b;
        ans.read_value = '0;
        ans.status     = STATUS_DONE;
        if (mode == MODE_READ)
        begin
            if (pos < LEAVES)
            begin
                ans.read_value = FIELD_W'($signed(leaf_read(pos)));
            end
            return ans;
        end
        if (stamp_now == '0)
        begin
            ans.status = STATUS_REFUSED;
            return ans;
        end
        a = (l > LEAVES) ? LEAVES : int'(l);
        b = (r > LEAVES) ? LEAVES : int'(r);
        if (a < b)
        begin
            paint(0, 0, TREE_N, a, b, VALUE_BITS'(value));
        end
        stamp_now = stamp_now + 1'b1;
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t got;
        answer_t want;
        if (!rst_n)
        begin
            foreach (node_val[i])
            begin
                node_val[i] = '0;
                node_age[i] = '0;
            end
            stamp_now = STAMP_BITS'(1);
            due_answers.delete();
            faults = 0;
        end
        else
        begin
            // result first: a command taken this edge cannot have answered yet
            if (res.valid && res.ready)
            begin
                got.read_value = res.read_value;
                got.status     = res.status;
                if (due_answers.size() == 0)
                begin
                    faults++;
                    if (faults <= 10)
                    begin
                        $display("unexpected result: read_value %0d status %0b",
                                 got.read_value, got.status);
                    end
                end
                else
                begin
                    want = due_answers.pop_front();
                    if (got.read_value !== want.read_value || got.status !== want.status)
                    begin
                        faults++;
                        if (faults <= 10)
                        begin
                            $display("mismatch: read_value exp %0d got %0d, status exp %0b got %0b",
                                     want.read_value, got.read_value, want.status, got.status);
                        end
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                due_answers.push_back(tree_answer(cmd.mode, cmd.left, cmd.right,
                                                  cmd.value, cmd.position));
            end
        end
        fail_count <= faults;
        pending    <= due_answers.size();
    end

endmodule

### test/range_assign_point_query_tree_unit_test.sv
// Testbench top: directed and random tree commands, handshake pressure and verdict
module range_assign_point_query_tree_unit_test;
    import rapq_pkg::*;

    localparam int IDLE_LIMIT  = 20000;
    localparam int HOLD_CYCLES = 400;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   stall_asks = 0;
    int   stall_done = 0;
    bit   calm       = 1'b0;
    logic [EDGE_W-1:0] last_left  = '0;
    logic [EDGE_W-1:0] last_right = '0;

    rapq_cmd_if cmd_ch ();
    rapq_res_if res_ch ();

    range_assign_point_query_tree_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    range_assign_point_query_tree_unit_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .res        (res_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(40, 150);
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic issue(input logic mode, input logic [EDGE_W-1:0] l,
                         input logic [EDGE_W-1:0] r, input logic [FIELD_W-1:0] v,
                         input logic [POS_W-1:0] p, input int gap);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.mode     <= mode;
        cmd_ch.left     <= l;
        cmd_ch.right    <= r;
        cmd_ch.value    <= v;
        cmd_ch.position <= p;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic put_read(input logic [POS_W-1:0] p);
        issue(MODE_READ, EDGE_W'($urandom), EDGE_W'($urandom), $urandom, p, pick_gap());
    endtask

    task automatic put_assign(input logic [EDGE_W-1:0] l, input logic [EDGE_W-1:0] r,
                              input logic [FIELD_W-1:0] v);
        issue(MODE_ASSIGN, l, r, v, POS_W'($urandom), pick_gap());
    endtask

    // sender goes quiet until every expected result has come
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic random_cmd(input int gap);
        int                 s;
        logic [EDGE_W-1:0]  l;
        logic [EDGE_W-1:0]  r;
        logic [FIELD_W-1:0] v;
        logic [POS_W-1:0]   p;
        l = EDGE_W'($urandom);
        r = EDGE_W'($urandom);
        v = $urandom;
        p = POS_W'($urandom);
        if ($urandom_range(0, 99) < 50)
        begin
            // reads near the edges of the last range find the boundaries
            case ($urandom_range(0, 5))
                0: p = POS_W'(last_left);
                1: p = POS_W'(last_left - 1'b1);
                2: p = POS_W'(last_right - 1'b1);
                3: p = POS_W'(last_right);
                default: p = POS_W'($urandom);
            endcase
            issue(MODE_READ, l, r, v, p, gap);
        end
        else
        begin
            s = $urandom_range(0, 99);
            l = EDGE_W'($urandom_range(0, LEAVES - 1));
            if (s < 55)
            begin
                r = l + EDGE_W'($urandom_range(0, 16));
            end
            else if (s < 80)
            begin
                r = EDGE_W'($urandom_range(l, LEAVES));
            end
            else if (s < 92)
            begin
                l = EDGE_W'($urandom);
                r = EDGE_W'($urandom);
            end
            else
            begin
                r = l - EDGE_W'($urandom_range(1, 8));
            end
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'h0000_0000;
                    1: v = 32'hFFFF_FFFF;
                    2: v = 32'h7FFF_FFFF;
                    default: v = 32'h8000_0000;
                endcase
            end
            last_left  = l;
            last_right = r;
            issue(MODE_ASSIGN, l, r, v, p, gap);
        end
    endtask

    // receiver
    initial
    begin
        int g;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_done < stall_asks)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                stall_done++;
            end
            else
            begin
                g = pick_gap();
                if (g > 0)
                begin
                    res_ch.ready <= 1'b0;
                    repeat (g) @(negedge clk);
                end
                res_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on transfer activity
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        cmd_ch.valid    = 1'b0;
        cmd_ch.mode     = MODE_ASSIGN;
        cmd_ch.left     = '0;
        cmd_ch.right    = '0;
        cmd_ch.value    = '0;
        cmd_ch.position = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        put_read(10'd0);
        put_read(10'd1023);
        put_assign(11'd0, 11'd1024, 32'h7FFF_FFFF);
        put_read(10'd0);
        put_read(10'd1023);
        put_assign(11'd0, 11'd0, 32'h1234_5678);
        put_read(10'd5);
        put_assign(11'd1023, 11'd1024, 32'h8000_0000);
        put_read(10'd1023);
        put_read(10'd1022);
        put_assign(11'd2047, 11'd2047, 32'hDEAD_BEEF);
        put_assign(11'd1000, 11'd2047, 32'hFFFF_FFFF);
        put_read(10'd1000);
        put_read(10'd999);
        put_assign(11'd5, 11'd3, 32'h0BAD_0BAD);
        put_assign(11'd2047, 11'd0, 32'h0BAD_0BAD);
        put_assign(11'd1, 11'd1023, 32'h5555_5555);
        put_read(10'd0);
        put_read(10'd1);
        put_read(10'd512);
        put_read(10'd1022);
        put_assign(11'd512, 11'd513, 32'hAAAA_AAAA);
        put_read(10'd512);
        put_assign(11'd1024, 11'd1024, 32'h0000_0001);
        put_read(10'd511);
        drain();

        // hold the receiver off and keep offering until the input stalls
        stall_asks <= stall_asks + 1;
        repeat (40) random_cmd(0);
        drain();

        for (int blk = 0; blk < 6; blk++)
        begin
            calm = (blk == 2);
            repeat (250) random_cmd(pick_gap());
            if (blk % 2 == 1)
            begin
                drain();
            end
        end
        calm = 1'b0;

        drain();
        repeat (60) @(negedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### range_assign_point_query_tree_unit.f
+incdir+src
src/rapq_pkg.sv
src/rapq_if.sv
src/rapq_ram.sv
src/rapq_ctrl.sv
src/range_assign_point_query_tree_unit.sv
test/range_assign_point_query_tree_unit_checker.sv
test/range_assign_point_query_tree_unit_test.sv
